@@ sv/vfpn_pkg.sv @@
// vfpn_pkg: types, widths and constants for the view frustum plane normal pipeline
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package vfpn_pkg;

	localparam int VECTOR_FRAC_BITS = 14;

	localparam int VEC_W      = 16;
	localparam int POS_W      = 24;
	localparam int PROD_W     = 29;                 // vector component times pixel count
	localparam int CORNER_W   = 31;                 // sum of three such products
	localparam int XPROD_W    = 2 * CORNER_W;       // corner component product
	localparam int CROSS_W    = XPROD_W + 1;        // cross product component
	localparam int BITS_W     = 7;                  // bit count of a cross magnitude
	localparam int MAG_W      = 30;                 // normalized magnitude
	localparam int SQ_W       = 2 * MAG_W + 2;      // sum of three squares
	localparam int RT_X_W     = SQ_W + 1;
	localparam int ROOT_W     = 31;
	localparam int RT_ITERS   = 32;
	localparam int RT_STAGES  = RT_ITERS / 2;
	localparam int QUO_W      = VECTOR_FRAC_BITS + 2;
	localparam int DIV_W      = ROOT_W + QUO_W;
	localparam int DIV_STAGES = (QUO_W + 1) / 2;
	localparam int SAT_W      = (QUO_W > 17) ? QUO_W : 17;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_DISTANCE = 2'd2;

	localparam logic [2:0] PLANE_NEAR   = 3'd0;
	localparam logic [2:0] PLANE_TOP    = 3'd1;
	localparam logic [2:0] PLANE_RIGHT  = 3'd2;
	localparam logic [2:0] PLANE_BOTTOM = 3'd3;
	localparam logic [2:0] PLANE_LEFT   = 3'd4;

	localparam logic [1:0] CORNER_NE = 2'd0;
	localparam logic [1:0] CORNER_SE = 2'd1;
	localparam logic [1:0] CORNER_SW = 2'd2;
	localparam logic [1:0] CORNER_NW = 2'd3;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [VEC_W-1:0] fwd_x;
		logic signed [VEC_W-1:0] fwd_y;
		logic signed [VEC_W-1:0] fwd_z;
		logic signed [VEC_W-1:0] up_x;
		logic signed [VEC_W-1:0] up_y;
		logic signed [VEC_W-1:0] up_z;
		logic signed [VEC_W-1:0] side_x;
		logic signed [VEC_W-1:0] side_y;
		logic signed [VEC_W-1:0] side_z;
	} pose_t;

	typedef struct packed {
		logic [2:0]              plane_index;
		logic signed [VEC_W-1:0] normal_x;
		logic signed [VEC_W-1:0] normal_y;
		logic signed [VEC_W-1:0] normal_z;
		logic                    last_plane;
	} plane_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} vec3_t;

	// sideband that travels with each plane through the pipeline
	typedef struct packed {
		logic       valid;
		logic [2:0] idx;
		logic [2:0] neg;
		logic       zero;
		vec3_t      fwd;
	} meta_t;

	// first and second corner of the cross product for a side plane
	function automatic logic [1:0] corner_of(input logic [2:0] idx, input logic second);
		logic [1:0] c;
		c = CORNER_NE;
		case (idx)
			PLANE_TOP:    c = second ? CORNER_NW : CORNER_NE;
			PLANE_RIGHT:  c = second ? CORNER_NE : CORNER_SE;
			PLANE_BOTTOM: c = second ? CORNER_SE : CORNER_SW;
			PLANE_LEFT:   c = second ? CORNER_SW : CORNER_NW;
			default:      c = CORNER_NE;
		endcase
		return c;
	endfunction

endpackage

@@ sv/view_frustum_plane_normals.sv @@
// view_frustum_plane_normals: one pose in, five plane normals out (near, top, right, bottom, left)
// path: pose register and plane sequencer, front stages, square root stages, divide stages,
// then the output register; the planes follow one per cycle while the output is not stalled
// issue: the plane sequencer feeds one plane per cycle into the shared corner, cross, square root
// and divide pipeline while the output is not stalled; a new pose is taken with the last plane
// reset: asynchronous active low; configuration registers return to 640, 360 and 896, pipeline empties
// depends on vfpn_pkg, vfpn_front, vfpn_isqrt, vfpn_div
`timescale 1ns / 1ps

module view_frustum_plane_normals (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pose_valid,
	output logic                               pose_ready,
	input  vfpn_pkg::pose_t                    pose,
	output logic                               plane_valid,
	input  logic                               plane_ready,
	output vfpn_pkg::plane_t                   plane,
	input  logic                               cfg_we,
	input  logic [vfpn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vfpn_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [11:0]      half_width_q;
	logic [11:0]      half_height_q;
	logic [12:0]      screen_distance_q;
	vfpn_pkg::pose_t  pose_q;
	logic             busy_q;
	logic [2:0]       cnt_q;
	logic             valid_q;
	vfpn_pkg::plane_t plane_q;
	logic             en;
	logic             accept;

	logic [vfpn_pkg::SQ_W-1:0]           sum_sq;
	logic [2:0][vfpn_pkg::MAG_W-1:0]     mag_f, mag_r;
	vfpn_pkg::meta_t                     meta_f, meta_r;
	logic [vfpn_pkg::ROOT_W-1:0]         root;
	logic                                res_valid;
	vfpn_pkg::plane_t                    res;

	assign en         = !valid_q || plane_ready;
	assign pose_ready = !busy_q || (cnt_q == vfpn_pkg::PLANE_LEFT && en);
	assign accept     = pose_valid && pose_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q      <= 12'd640;
			half_height_q     <= 12'd360;
			screen_distance_q <= 13'd896;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vfpn_pkg::CFG_HALF_WIDTH:      half_width_q      <= cfg_data[11:0];
				vfpn_pkg::CFG_HALF_HEIGHT:     half_height_q     <= cfg_data[11:0];
				vfpn_pkg::CFG_SCREEN_DISTANCE: screen_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// plane sequencer: issues planes 0 to 4 of the held pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= vfpn_pkg::PLANE_NEAR;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= vfpn_pkg::PLANE_NEAR;
		end else if (busy_q && en) begin
			if (cnt_q == vfpn_pkg::PLANE_LEFT) begin
				busy_q <= 1'b0;
				cnt_q  <= vfpn_pkg::PLANE_NEAR;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) pose_q <= pose;
	end

	vfpn_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.issue_valid     (busy_q),
		.issue_idx       (cnt_q),
		.pose            (pose_q),
		.half_width      (half_width_q),
		.half_height     (half_height_q),
		.screen_distance (screen_distance_q),
		.sum_sq          (sum_sq),
		.mag             (mag_f),
		.meta            (meta_f)
	);

	vfpn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.sum_sq   (sum_sq),
		.mag_in   (mag_f),
		.meta_in  (meta_f),
		.root     (root),
		.mag_out  (mag_r),
		.meta_out (meta_r)
	);

	vfpn_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.root         (root),
		.mag_in       (mag_r),
		.meta_in      (meta_r),
		.result_valid (res_valid),
		.result       (res)
	);

	// output register; the whole pipeline holds while a transaction waits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) plane_q <= res;
	end

	assign plane_valid = valid_q;
	assign plane       = plane_q;

endmodule

@@ sv/vfpn_front.sv @@
// vfpn_front: corners, cross product, magnitude scaling and sum of squares (stages 1 to 9)
// depends on vfpn_pkg
`timescale 1ns / 1ps

module vfpn_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     issue_valid,
	input  logic [2:0]                               issue_idx,
	input  vfpn_pkg::pose_t                          pose,
	input  logic [11:0]                              half_width,
	input  logic [11:0]                              half_height,
	input  logic [12:0]                              screen_distance,
	output logic [vfpn_pkg::SQ_W-1:0]                sum_sq,
	output logic [2:0][vfpn_pkg::MAG_W-1:0]          mag,
	output vfpn_pkg::meta_t                          meta
);

	localparam int PW = vfpn_pkg::PROD_W;
	localparam int CW = vfpn_pkg::CORNER_W;
	localparam int XW = vfpn_pkg::XPROD_W;
	localparam int RW = vfpn_pkg::CROSS_W;
	localparam int MW = vfpn_pkg::MAG_W;
	localparam int BW = vfpn_pkg::BITS_W;

	logic signed [vfpn_pkg::VEC_W-1:0] f [3];
	logic signed [vfpn_pkg::VEC_W-1:0] u [3];
	logic signed [vfpn_pkg::VEC_W-1:0] s [3];

	vfpn_pkg::meta_t meta_in, meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	vfpn_pkg::meta_t meta_s7, meta_s8, meta_s9, meta_s7_d, meta_s4_d;

	logic signed [PW-1:0] fd_s1 [3];
	logic signed [PW-1:0] uh_s1 [3];
	logic signed [PW-1:0] sw_s1 [3];
	logic signed [CW-1:0] a_s2 [3];
	logic signed [CW-1:0] b_s2 [3];
	logic signed [XW-1:0] p_s3 [6];
	logic [RW-1:0]        cabs_s4 [3];
	logic [RW-1:0]        cabs_s5 [3];
	logic [3:0]           chunk_nz_s5;
	logic [3:0]           chunk_pos_s5 [4];
	logic [RW-1:0]        cabs_s6 [3];
	logic [BW-1:0]        bits_s6;
	logic [MW-1:0]        mag_s7 [3];
	logic [2*MW-1:0]      sq_s8 [3];
	logic [MW-1:0]        mag_s8 [3];
	logic [vfpn_pkg::SQ_W-1:0] sum_s9;
	logic [MW-1:0]        mag_s9 [3];

	logic signed [CW-1:0] a_c [3];
	logic signed [CW-1:0] b_c [3];
	logic signed [RW-1:0] c_c [3];
	logic [3:0]           nz_c;
	logic [3:0]           pos_c [4];
	logic [BW-1:0]        bits_c;
	logic [MW-1:0]        mag_c [3];
	logic [2:0]           neg_c;
	logic [1:0]           ca, cb;

	assign f[0] = pose.fwd_x;
	assign f[1] = pose.fwd_y;
	assign f[2] = pose.fwd_z;
	assign u[0] = pose.up_x;
	assign u[1] = pose.up_y;
	assign u[2] = pose.up_z;
	assign s[0] = pose.side_x;
	assign s[1] = pose.side_y;
	assign s[2] = pose.side_z;

	always_comb begin
		meta_in       = '0;
		meta_in.valid = issue_valid;
		meta_in.idx   = issue_idx;
		meta_in.fwd.x = pose.fwd_x;
		meta_in.fwd.y = pose.fwd_y;
		meta_in.fwd.z = pose.fwd_z;
	end

	// corner assembly: sign of the up and side terms from the corner code
	always_comb begin
		ca = vfpn_pkg::corner_of(meta_s1.idx, 1'b0);
		cb = vfpn_pkg::corner_of(meta_s1.idx, 1'b1);
		for (int i = 0; i < 3; i++) begin
			a_c[i] = CW'(fd_s1[i])
				+ ((ca == vfpn_pkg::CORNER_SE || ca == vfpn_pkg::CORNER_SW) ?
					-CW'(uh_s1[i]) : CW'(uh_s1[i]))
				+ ((ca == vfpn_pkg::CORNER_SW || ca == vfpn_pkg::CORNER_NW) ?
					-CW'(sw_s1[i]) : CW'(sw_s1[i]));
			b_c[i] = CW'(fd_s1[i])
				+ ((cb == vfpn_pkg::CORNER_SE || cb == vfpn_pkg::CORNER_SW) ?
					-CW'(uh_s1[i]) : CW'(uh_s1[i]))
				+ ((cb == vfpn_pkg::CORNER_SW || cb == vfpn_pkg::CORNER_NW) ?
					-CW'(sw_s1[i]) : CW'(sw_s1[i]));
		end
	end

	always_comb begin
		c_c[0] = RW'(p_s3[0]) - RW'(p_s3[1]);
		c_c[1] = RW'(p_s3[2]) - RW'(p_s3[3]);
		c_c[2] = RW'(p_s3[4]) - RW'(p_s3[5]);
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = c_c[i][RW-1];
		end
	end

	always_comb begin
		meta_s4_d     = meta_s3;
		meta_s4_d.neg = neg_c;
	end

	// leading one of the or of the magnitudes, in 16-bit chunks
	always_comb begin
		logic [63:0] orv;
		orv = 64'(cabs_s4[0] | cabs_s4[1] | cabs_s4[2]);
		for (int k = 0; k < 4; k++) begin
			nz_c[k]  = |orv[16*k +: 16];
			pos_c[k] = 4'd0;
			for (int j = 0; j < 16; j++) begin
				if (orv[16*k + j]) pos_c[k] = 4'(j);
			end
		end
	end

	always_comb begin
		bits_c = '0;
		for (int k = 0; k < 4; k++) begin
			if (chunk_nz_s5[k]) bits_c = BW'(16 * k) + BW'(chunk_pos_s5[k]) + BW'(1);
		end
	end

	always_comb begin
		logic [RW-1:0] sh;
		meta_s7_d      = meta_s6;
		meta_s7_d.zero = (bits_s6 == '0);
		for (int i = 0; i < 3; i++) begin
			if (bits_s6 > BW'(MW)) sh = cabs_s6[i] >> (bits_s6 - BW'(MW));
			else sh = cabs_s6[i] << (BW'(MW) - bits_s6);
			mag_c[i] = sh[MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
			meta_s6 <= '0;
			meta_s7 <= '0;
			meta_s8 <= '0;
			meta_s9 <= '0;
		end else if (en) begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s4_d;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s7_d;
			meta_s8 <= meta_s7;
			meta_s9 <= meta_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				fd_s1[i]   <= PW'(f[i] * $signed({1'b0, screen_distance}));
				uh_s1[i]   <= PW'(u[i] * $signed({1'b0, half_height}));
				sw_s1[i]   <= PW'(s[i] * $signed({1'b0, half_width}));
				a_s2[i]    <= a_c[i];
				b_s2[i]    <= b_c[i];
				cabs_s4[i] <= neg_c[i] ? RW'(-c_c[i]) : RW'(c_c[i]);
				cabs_s5[i] <= cabs_s4[i];
				cabs_s6[i] <= cabs_s5[i];
				mag_s7[i]  <= mag_c[i];
				sq_s8[i]   <= mag_s7[i] * mag_s7[i];
				mag_s8[i]  <= mag_s7[i];
				mag_s9[i]  <= mag_s8[i];
			end
			p_s3[0] <= XW'(a_s2[1] * b_s2[2]);
			p_s3[1] <= XW'(a_s2[2] * b_s2[1]);
			p_s3[2] <= XW'(a_s2[2] * b_s2[0]);
			p_s3[3] <= XW'(a_s2[0] * b_s2[2]);
			p_s3[4] <= XW'(a_s2[0] * b_s2[1]);
			p_s3[5] <= XW'(a_s2[1] * b_s2[0]);
			chunk_nz_s5 <= nz_c;
			for (int k = 0; k < 4; k++) begin
				chunk_pos_s5[k] <= pos_c[k];
			end
			bits_s6 <= bits_c;
			sum_s9  <= vfpn_pkg::SQ_W'(sq_s8[0]) + vfpn_pkg::SQ_W'(sq_s8[1])
				+ vfpn_pkg::SQ_W'(sq_s8[2]);
		end
	end

	assign sum_sq = sum_s9;
	assign mag[0] = mag_s9[0];
	assign mag[1] = mag_s9[1];
	assign mag[2] = mag_s9[2];
	assign meta   = meta_s9;

endmodule

@@ sv/vfpn_isqrt.sv @@
// vfpn_isqrt: pipelined floor square root, two result bits per stage
// depends on vfpn_pkg
`timescale 1ns / 1ps

module vfpn_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [vfpn_pkg::SQ_W-1:0]           sum_sq,
	input  logic [2:0][vfpn_pkg::MAG_W-1:0]     mag_in,
	input  vfpn_pkg::meta_t                     meta_in,
	output logic [vfpn_pkg::ROOT_W-1:0]         root,
	output logic [2:0][vfpn_pkg::MAG_W-1:0]     mag_out,
	output vfpn_pkg::meta_t                     meta_out
);

	localparam int XW = vfpn_pkg::RT_X_W;
	localparam int NS = vfpn_pkg::RT_STAGES;

	logic [XW-1:0]                        x_s [NS];
	logic [XW-1:0]                        r_s [NS];
	logic [2:0][vfpn_pkg::MAG_W-1:0]      mag_s [NS];
	vfpn_pkg::meta_t                      meta_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [XW-1:0]                   x_p, r_p, x_n, r_n;
		logic [2:0][vfpn_pkg::MAG_W-1:0] mag_p;
		vfpn_pkg::meta_t                 meta_p;

		if (g == 0) begin : g_first
			assign x_p    = XW'(sum_sq);
			assign r_p    = '0;
			assign mag_p  = mag_in;
			assign meta_p = meta_in;
		end else begin : g_next
			assign x_p    = x_s[g-1];
			assign r_p    = r_s[g-1];
			assign mag_p  = mag_s[g-1];
			assign meta_p = meta_s[g-1];
		end

		always_comb begin
			logic [XW-1:0] bitv;
			x_n = x_p;
			r_n = r_p;
			for (int t = 0; t < 2; t++) begin
				bitv = XW'(1) << (XW - 1 - 2 * (2 * g + t));
				if (x_n >= r_n + bitv) begin
					x_n = x_n - (r_n + bitv);
					r_n = (r_n >> 1) + bitv;
				end else begin
					r_n = r_n >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_s[g] <= '0;
			end else if (en) begin
				meta_s[g] <= meta_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g]   <= x_n;
				r_s[g]   <= r_n;
				mag_s[g] <= mag_p;
			end
		end
	end

	assign root     = r_s[NS-1][vfpn_pkg::ROOT_W-1:0];
	assign mag_out  = mag_s[NS-1];
	assign meta_out = meta_s[NS-1];

endmodule

@@ sv/vfpn_div.sv @@
// vfpn_div: rounded quotient of each magnitude by the length, three lanes,
// two quotient bits per stage, then saturation, sign and plane formatting
// depends on vfpn_pkg
`timescale 1ns / 1ps

module vfpn_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [vfpn_pkg::ROOT_W-1:0]         root,
	input  logic [2:0][vfpn_pkg::MAG_W-1:0]     mag_in,
	input  vfpn_pkg::meta_t                     meta_in,
	output logic                                result_valid,
	output vfpn_pkg::plane_t                    result
);

	localparam int DW = vfpn_pkg::DIV_W;
	localparam int QW = vfpn_pkg::QUO_W;
	localparam int NS = vfpn_pkg::DIV_STAGES;
	localparam int SW = vfpn_pkg::SAT_W;

	logic [DW-1:0]                   rem_s [NS][3];
	logic [QW-1:0]                   q_s [NS][3];
	logic [vfpn_pkg::ROOT_W-1:0]     len_s [NS];
	vfpn_pkg::meta_t                 meta_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [DW-1:0]               rem_p [3];
		logic [QW-1:0]               q_p [3];
		logic [DW-1:0]               rem_n [3];
		logic [QW-1:0]               q_n [3];
		logic [vfpn_pkg::ROOT_W-1:0] len_p;
		vfpn_pkg::meta_t             meta_p;

		if (g == 0) begin : g_first
			assign len_p  = root;
			assign meta_p = meta_in;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_p[i] = (DW'(mag_in[i]) << vfpn_pkg::VECTOR_FRAC_BITS)
					+ DW'(root >> 1);
				assign q_p[i]   = '0;
			end
		end else begin : g_next
			assign len_p  = len_s[g-1];
			assign meta_p = meta_s[g-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_p[i] = rem_s[g-1][i];
				assign q_p[i]   = q_s[g-1][i];
			end
		end

		always_comb begin
			logic [DW-1:0] dsh;
			for (int i = 0; i < 3; i++) begin
				rem_n[i] = rem_p[i];
				q_n[i]   = q_p[i];
				for (int t = 0; t < 2; t++) begin
					if (QW - 1 - (2 * g + t) >= 0) begin
						dsh = DW'(len_p) << (QW - 1 - (2 * g + t));
						if (rem_n[i] >= dsh) begin
							rem_n[i] = rem_n[i] - dsh;
							q_n[i][QW - 1 - (2 * g + t)] = 1'b1;
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_s[g] <= '0;
			end else if (en) begin
				meta_s[g] <= meta_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[g] <= len_p;
				for (int i = 0; i < 3; i++) begin
					rem_s[g][i] <= rem_n[i];
					q_s[g][i]   <= q_n[i];
				end
			end
		end
	end

	vfpn_pkg::meta_t                   mf;
	logic signed [vfpn_pkg::VEC_W-1:0] nrm [3];

	assign mf = meta_s[NS-1];

	// clamp magnitude to 32768, apply sign, clamp positive side to 32767; zero when the cross product was zero
	always_comb begin
		logic [SW-1:0]     qx;
		logic signed [16:0] sv;
		for (int i = 0; i < 3; i++) begin
			qx = SW'(q_s[NS-1][i]);
			if (qx > SW'(32768)) qx = SW'(32768);
			sv = mf.neg[i] ? -$signed({1'b0, qx[15:0]}) - 17'sd0 : $signed({1'b0, qx[15:0]});
			if (qx[15:0] == 16'd0 && qx[16]) sv = mf.neg[i] ? -17'sd32768 : 17'sd32767;
			if (sv > 17'sd32767) sv = 17'sd32767;
			nrm[i] = mf.zero ? 16'sd0 : sv[15:0];
		end
	end

	always_comb begin
		result.plane_index = mf.idx;
		result.last_plane  = (mf.idx == vfpn_pkg::PLANE_LEFT);
		if (mf.idx == vfpn_pkg::PLANE_NEAR) begin
			result.normal_x = mf.fwd.x;
			result.normal_y = mf.fwd.y;
			result.normal_z = mf.fwd.z;
		end else begin
			result.normal_x = nrm[0];
			result.normal_y = nrm[1];
			result.normal_z = nrm[2];
		end
	end

	assign result_valid = mf.valid;

endmodule
